// ===== hdl/projectile_step_with_heading_unit_assert.svh =====
// Assertion macros for the projectile step unit.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef PROJECTILE_STEP_WITH_HEADING_UNIT_ASSERT_SVH
`define PROJECTILE_STEP_WITH_HEADING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSWH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PSWH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pswh_pkg.sv =====
// Shared types, constants and helper functions of the projectile step unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pswh_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int ANG_W        = 14;

    localparam logic [15:0] GRAVITY_RESET = 16'd2511;
    localparam logic        REG_GRAVITY   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ANGLE,
        S_CLIMB,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ITER,
        C_DONE
    } cphase_t;

    // Arctangent of 2^-i in degrees, Q.16.
    function automatic logic [21:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [21:0] r;
        case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat_to32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
            r = v[31:0];
        else if (v[33])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    function automatic logic signed [23:0] sat_to24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v[25:23] == 3'b000 || v[25:23] == 3'b111)
            r = v[23:0];
        else if (v[25])
            r = 24'sh80_0000;
        else
            r = 24'sh7F_FFFF;
        return r;
    endfunction

endpackage

// ===== hdl/projectile_step_with_heading_unit.sv =====
// Top level of the projectile step unit: register port, stream ports and sequencer.
// Depends on pswh_pkg, pswh_cordic, pswh_isqrt and the assertion macro header.
//
//  Channel  Direction  Transfer when            Contents
//  s_*      in         s_tvalid & s_tready      one launch or tick item
//  m_*      out        m_tvalid & m_tready      position, yaw and pitch
//  APB      in/out     psel&penable&pwrite      gravity register at byte 0
//
// A tick runs the shared multiplier through steps 0 to 8, a launch through steps 6
// to 8; then the square root (32 steps) and the heading CORDIC run side by side,
// and the climb CORDIC follows (normalisation, sixteen steps and a done state).
// Reset clears the state to zero and gravity to 2511. The unit takes a new item
// while a finished result still waits on the output; it waits only to load it.
`timescale 1ns / 1ps

module projectile_step_with_heading_unit
(
    input  logic         clk,
    input  logic         rst_n,
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [183:0] s_tdata,  // delta_t, start_x, start_y, start_z, launch_vx,
                                   // launch_vy, launch_vz (lowest bits first)
    input  logic         s_tuser,  // kind: 0 launch, 1 tick
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // pos_x, pos_y, pos_z, yaw_out, pitch_out
);
    import pswh_pkg::*;

    state_t state_reg, state_next;
    logic [3:0]  mstep_reg, mstep_next;
    logic [15:0] gravity_reg;
    logic        kind_reg;
    logic [15:0] dt_reg;

    logic signed [31:0] pos_reg  [3];
    logic signed [31:0] pos_next [3];
    logic signed [23:0] vel_reg  [3];
    logic signed [23:0] vel_next [3];

    logic signed [57:0] prod_reg;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic [31:0]        gdt_reg;
    logic signed [40:0] nvzdt_reg;
    logic signed [59:0] num_reg;
    logic [47:0]        sq_reg;

    logic [ANG_W-1:0] head_reg;
    logic             hdone_reg;
    logic             sdone_reg;
    logic [31:0]      h_reg;
    logic [16:0]      yaw_reg;
    logic [14:0]      pitch_reg;

    logic         out_valid_reg;
    logic [127:0] out_data_reg;

    logic [23:0] avx, avy, avz;
    logic        in_xfer, load_out;

    // Rounding and update arithmetic on the registered product.
    logic [32:0]        gdt_rnd;
    logic signed [25:0] vz_diff;
    logic signed [57:0] dxy_sum;
    logic signed [33:0] dxy;
    logic signed [59:0] dz_sum;
    logic signed [33:0] dz;
    logic signed [59:0] num_calc;
    logic [47:0]        sq_sum;

    logic               cor_start, cor_done;
    logic [31:0]        cor_ax, cor_ay;
    logic [ANG_W-1:0]   cor_angle;
    logic               sq_start, sq_done;
    logic [31:0]        sq_root;
    logic [16:0]        heading;
    logic [16:0]        head17;
    logic [14:0]        climb15;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // Magnitudes of the current velocity.
    assign avx = vel_reg[0][23] ? (~vel_reg[0] + 24'd1) : vel_reg[0];
    assign avy = vel_reg[1][23] ? (~vel_reg[1] + 24'd1) : vel_reg[1];
    assign avz = vel_reg[2][23] ? (~vel_reg[2] + 24'd1) : vel_reg[2];

    // ---------------------------------------------------------------
    // Register port. Only the gravity register exists.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GRAVITY) ? {16'd0, gravity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gravity_reg <= GRAVITY_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_GRAVITY)
            gravity_reg <= pwdata[15:0];
    end

    // ---------------------------------------------------------------
    // Shared multiplier. Operands are chosen by the step counter; the
    // product is registered and used by the following step.
    //   0 g*dt   1 vx*dt   2 vy*dt   3 vz'*dt   4 gdt*dt   6 |vx|^2   7 |vy|^2
    // ---------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = $signed({9'd0, dt_reg});
        case (mstep_reg)
            4'd0: mul_a = $signed({17'd0, gravity_reg});
            4'd1: mul_a = 33'(vel_reg[0]);
            4'd2: mul_a = 33'(vel_reg[1]);
            4'd3: mul_a = 33'(vel_reg[2]);
            4'd4: mul_a = $signed({1'b0, gdt_reg});
            4'd6:
            begin
                mul_a = $signed({9'd0, avx});
                mul_b = $signed({1'b0, avx});
            end
            4'd7:
            begin
                mul_a = $signed({9'd0, avy});
                mul_b = $signed({1'b0, avy});
            end
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign gdt_rnd  = {1'b0, prod_reg[31:0]} + 33'd32768;
    assign vz_diff  = 26'(vel_reg[2]) - $signed({9'd0, gdt_rnd[32:16]});
    assign dxy_sum  = prod_reg + 58'sd32768;
    assign dxy      = dxy_sum[49:16];
    // z numerator: vz'*dt*2^17 minus g*dt*dt.
    assign num_calc = (60'(nvzdt_reg) <<< 17) - 60'(prod_reg);
    assign dz_sum   = num_reg + 60'sh1_0000_0000;
    assign dz       = 34'($signed(dz_sum[59:33]));
    assign sq_sum   = sq_reg + prod_reg[47:0];

    // ---------------------------------------------------------------
    // Angle units. The heading CORDIC runs alongside the square root,
    // the climb angle then reuses the same CORDIC.
    // ---------------------------------------------------------------
    assign sq_start  = (state_reg == S_MUL) && (mstep_reg == 4'd8);
    assign cor_start = sq_start || ((state_reg == S_ANGLE) && hdone_reg && sdone_reg);
    assign cor_ax    = (state_reg == S_MUL) ? {8'd0, avx} : h_reg;
    assign cor_ay    = (state_reg == S_MUL) ? {8'd0, avy} : {avz, 8'd0};

    pswh_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n     ({sq_sum, 16'd0}),
        .done  (sq_done),
        .root  (sq_root)
    );

    pswh_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .ax    (cor_ax),
        .ay    (cor_ay),
        .done  (cor_done),
        .angle (cor_angle)
    );

    // Quadrant correction of the heading, then yaw and pitch.
    assign head17 = {3'd0, head_reg};
    always_comb
    begin
        case ({vel_reg[0][23], vel_reg[1][23]})
            2'b00:   heading = head17;
            2'b10:   heading = 17'd23040 - head17;
            2'b11:   heading = 17'd23040 + head17;
            default: heading = 17'd46080 - head17;
        endcase
    end
    assign climb15 = {1'b0, cor_angle};

    // ---------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_MUL;
                    mstep_next = s_tuser ? 4'd0 : 4'd6;
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + 4'd1;
                if (mstep_reg == 4'd8)
                    state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                if (hdone_reg && sdone_reg)
                    state_next = S_CLIMB;
            end
            S_CLIMB:
            begin
                if (cor_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: state updates per step.
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pos_next[k] = pos_reg[k];
            vel_next[k] = vel_reg[k];
        end
        if (in_xfer && !s_tuser)
        begin
            pos_next[0] = s_tdata[47:16];
            pos_next[1] = s_tdata[79:48];
            pos_next[2] = s_tdata[111:80];
            vel_next[0] = s_tdata[135:112];
            vel_next[1] = s_tdata[159:136];
            vel_next[2] = s_tdata[183:160];
        end
        if (state_reg == S_MUL)
        begin
            case (mstep_reg)
                4'd1: vel_next[2] = sat_to24(vz_diff);
                4'd2: pos_next[0] = sat_to32(34'(pos_reg[0]) + dxy);
                4'd3: pos_next[1] = sat_to32(34'(pos_reg[1]) + dxy);
                4'd6:
                begin
                    if (kind_reg)
                        pos_next[2] = sat_to32(34'(pos_reg[2]) + dz);
                end
                default: pos_next[0] = pos_reg[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mstep_reg     <= 4'd0;
            hdone_reg     <= 1'b0;
            sdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
                vel_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= pos_next[k];
                vel_reg[k] <= vel_next[k];
            end
            if (sq_start)
            begin
                hdone_reg <= 1'b0;
                sdone_reg <= 1'b0;
            end
            else if (state_reg == S_ANGLE)
            begin
                if (cor_done)
                    hdone_reg <= 1'b1;
                if (sq_done)
                    sdone_reg <= 1'b1;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= s_tuser;
            dt_reg   <= s_tdata[15:0];
        end
        if (state_reg == S_MUL)
        begin
            case (mstep_reg)
                4'd1: gdt_reg   <= prod_reg[31:0];
                4'd4: nvzdt_reg <= prod_reg[40:0];
                4'd5: num_reg   <= num_calc;
                4'd7: sq_reg    <= prod_reg[47:0];
                default: gdt_reg <= gdt_reg;
            endcase
        end
        if (state_reg == S_ANGLE && cor_done)
            head_reg <= cor_angle;
        if (state_reg == S_ANGLE && sq_done)
            h_reg <= sq_root;
        if (state_reg == S_CLIMB && cor_done)
        begin
            yaw_reg   <= 17'd11520 - heading;
            // Pitch is the negated climb angle, whose sign follows vz.
            pitch_reg <= vel_reg[2][23] ? climb15 : (~climb15 + 15'd1);
        end
        if (load_out)
            out_data_reg <= {pitch_reg, yaw_reg, pos_reg[2], pos_reg[1], pos_reg[0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "projectile_step_with_heading_unit_assert.svh"

    `PSWH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `PSWH_ASSERT_NOW(a_yaw_range, m_tvalid, ($signed(m_tdata[112:96]) >= -17'sd34560) && ($signed(m_tdata[112:96]) <= 17'sd11520), "yaw out of range")
    `PSWH_ASSERT_NOW(a_pitch_range, m_tvalid, ($signed(m_tdata[127:113]) >= -15'sd11520) && ($signed(m_tdata[127:113]) <= 15'sd11520), "pitch out of range")

endmodule

// ===== hdl/pswh_isqrt.sv =====
// Bit-pair integer square root of a 64-bit value, one pair per cycle.
// Depends on pswh_pkg.
`timescale 1ns / 1ps

module pswh_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] n,
    output logic        done,
    output logic [31:0] root
);
    import pswh_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  k_reg, k_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_val;
    logic [63:0] trial;

    assign bit_val = 64'd1 << {k_reg, 1'b0};
    assign trial   = r_reg + bit_val;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = 5'd31;
            n_next    = n;
            r_next    = 64'd0;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next = n_reg - trial;
                r_next = (r_reg >> 1) + bit_val;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            k_next = k_reg - 5'd1;
            if (k_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        n_reg <= n_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

// ===== hdl/pswh_cordic.sv =====
// Vectoring CORDIC for first-quadrant arctangent in degrees Q.7.
// Normalises the vector by shifts of one or four bits, then runs one step per cycle. Depends on pswh_pkg.
`timescale 1ns / 1ps

module pswh_cordic
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                ax,
    input  logic [31:0]                ay,
    output logic                       done,
    output logic [pswh_pkg::ANG_W-1:0] angle
);
    import pswh_pkg::*;

    cphase_t phase_reg, phase_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [24:0] z_reg, z_next;
    logic [STEP_W-1:0]  i_reg, i_next;
    logic [31:0]        mag;
    logic signed [33:0] dx, dy;
    logic signed [24:0] step_ang;
    logic [22:0]        z_clamp;
    logic [23:0]        z_round;

    assign mag      = x_reg[31:0] | y_reg[31:0];
    assign dx       = y_reg >>> i_reg;
    assign dy       = x_reg >>> i_reg;
    assign step_ang = $signed({3'b000, atan_deg(i_reg)});

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            C_IDLE:
            begin
                if (start)
                    phase_next = ((ax | ay) == 32'd0) ? C_DONE : C_NORM;
            end
            C_NORM:
            begin
                if (mag[31:30] == 2'b00 && mag[29])
                    phase_next = C_ITER;
            end
            C_ITER:
            begin
                if (i_reg == STEP_W'(CORDIC_STEPS - 1))
                    phase_next = C_DONE;
            end
            C_DONE:  phase_next = C_IDLE;
            default: phase_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        unique case (phase_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next = $signed({2'b00, ax});
                    y_next = $signed({2'b00, ay});
                    z_next = '0;
                    i_next = '0;
                end
            end
            C_NORM:
            begin
                // Bring the larger part into [2^29, 2^30).
                if (mag[31:30] != 2'b00)
                begin
                    x_next = x_reg >>> 1;
                    y_next = y_reg >>> 1;
                end
                else if (mag[29:25] == 5'd0)
                begin
                    x_next = x_reg <<< 4;
                    y_next = y_reg <<< 4;
                end
                else if (!mag[29])
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
            end
            C_ITER:
            begin
                if (!y_reg[33])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + step_ang;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - step_ang;
                end
                i_next = i_reg + STEP_W'(1);
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= C_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    // Clamp to a right angle and round to Q.7.
    always_comb
    begin
        if (z_reg[24])
            z_clamp = 23'd0;
        else if (z_reg > 25'sd5898240)
            z_clamp = 23'd5898240;
        else
            z_clamp = z_reg[22:0];
    end

    assign z_round = {1'b0, z_clamp} + 24'd256;
    assign angle   = z_round[22:9];
    assign done    = (phase_reg == C_DONE);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for projectile_step_with_heading_unit.
// Depends on the unit and pswh_pkg; a scoreboard class predicts each result.
`timescale 1ns / 1ps

class flight_scoreboard;
    bit [15:0]         gravity;
    logic signed [63:0] pos [3];
    logic signed [63:0] vel [3];
    bit [127:0]        pending [$];
    int                mismatches;

    function new();
        gravity = 16'd2511;
        foreach (pos[i])
        begin
            pos[i] = 0;
            vel[i] = 0;
        end
        mismatches = 0;
    endfunction

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -(longint'(1) << (w - 1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // First-quadrant arctangent in degrees Q.7.
    function automatic longint arctan_deg(longint unsigned ax, longint unsigned ay);
        longint x;
        longint y;
        longint z;
        longint ddx;
        longint ddy;
        longint tab [24];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        z = 0;
        if ((ax | ay) == 0)
            return 0;
        while ((ax | ay) >= (64'd1 << 30))
        begin
            ax >>= 1;
            ay >>= 1;
        end
        while ((ax | ay) < (64'd1 << 29))
        begin
            ax <<= 1;
            ay <<= 1;
        end
        x = ax;
        y = ay;
        for (int i = 0; i < pswh_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            ddx = floor_div(y, i);
            ddy = floor_div(x, i);
            if (y >= 0)
            begin
                x += ddx;
                y -= ddy;
                z += tab[i];
            end
            else
            begin
                x -= ddx;
                y += ddy;
                z -= tab[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > 90 * 65536)
            z = 90 * 65536;
        return (z + 256) >>> 9;
    endfunction

    function void note_item(bit tick, bit [183:0] d);
        longint dt;
        longint gdt;
        longint nvz;
        longint num;
        longint heading;
        longint climb;
        longint a;
        longint unsigned avx;
        longint unsigned avy;
        longint unsigned avz;
        bit [127:0] r;
        if (!tick)
        begin
            pos[0] = $signed(d[47:16]);
            pos[1] = $signed(d[79:48]);
            pos[2] = $signed(d[111:80]);
            vel[0] = $signed(d[135:112]);
            vel[1] = $signed(d[159:136]);
            vel[2] = $signed(d[183:160]);
        end
        else
        begin
            dt = d[15:0];
            gdt = longint'(gravity) * dt;
            nvz = clamp(vel[2] - round_div(gdt, 16), 24);
            vel[2] = nvz;
            pos[0] = clamp(pos[0] + round_div(vel[0] * dt, 16), 32);
            pos[1] = clamp(pos[1] + round_div(vel[1] * dt, 16), 32);
            num = nvz * dt * (longint'(1) << 17) - gdt * dt;
            pos[2] = clamp(pos[2] + round_div(num, 33), 32);
        end
        avx = vel[0] < 0 ? -vel[0] : vel[0];
        avy = vel[1] < 0 ? -vel[1] : vel[1];
        avz = vel[2] < 0 ? -vel[2] : vel[2];
        heading = 0;
        if ((avx | avy) != 0)
        begin
            a = arctan_deg(avx, avy);
            if (vel[0] >= 0 && vel[1] >= 0)
                heading = a;
            else if (vel[0] < 0 && vel[1] >= 0)
                heading = 23040 - a;
            else if (vel[0] < 0)
                heading = 23040 + a;
            else
                heading = 46080 - a;
        end
        climb = 0;
        if ((avx | avy | avz) != 0)
        begin
            a = arctan_deg(root64((avx * avx + avy * avy) << 16), avz << 8);
            climb = vel[2] < 0 ? -a : a;
        end
        r = '0;
        r[31:0] = pos[0][31:0];
        r[63:32] = pos[1][31:0];
        r[95:64] = pos[2][31:0];
        r[112:96] = 17'(11520 - heading);
        r[127:113] = 15'(-climb);
        pending.push_back(r);
    endfunction

    function void check_result(bit [127:0] got);
        bit [127:0] exp;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: pos %h/%h/%h yaw %h pitch %h, expected %h/%h/%h yaw %h pitch %h",
                         got[31:0], got[63:32], got[95:64], got[112:96], got[127:113],
                         exp[31:0], exp[63:32], exp[95:64], exp[112:96], exp[127:113]);
        end
    endfunction
endclass

module tb_top;
    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;   // delta_t, start_x, start_y, start_z, launch_vx, launch_vy, launch_vz
    logic         s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // pos_x, pos_y, pos_z, yaw_out, pitch_out

    localparam bit KIND_LAUNCH = 1'b0;
    localparam bit KIND_TICK   = 1'b1;

    flight_scoreboard sb;

    projectile_step_with_heading_unit u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Writes the gravity register through the two-phase register access.
    task automatic write_gravity(bit [15:0] g);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * pswh_pkg::REG_GRAVITY);
        pwdata  <= {16'd0, g};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.gravity = g;
    endtask

    // Offers one item after a random gap; the scoreboard notes it on transfer.
    // With no gap the valid line simply stays high for the next item.
    task automatic send_item(bit kind, bit [183:0] d, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(kind, d);
    endtask

    function automatic bit [183:0] launch_word(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                                               bit [23:0] vx, bit [23:0] vy, bit [23:0] vz);
        return {vz, vy, vx, z, y, x, 16'd0};
    endfunction

    function automatic bit [183:0] random_launch();
        bit [183:0] d;
        d = 184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        // Mostly moderate speeds and positions so that flights run a while.
        if ($urandom_range(0, 3) != 0)
            d = launch_word($urandom_range(0, 200000) - 100000,
                            $urandom_range(0, 200000) - 100000,
                            $urandom_range(0, 200000),
                            24'($urandom_range(0, 40000) - 20000),
                            24'($urandom_range(0, 40000) - 20000),
                            24'($urandom_range(0, 40000) - 20000));
        return d;
    endfunction

    function automatic bit [183:0] random_tick();
        bit [183:0] d;
        d = 184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 2) != 0)
            d[15:0] = 16'($urandom_range(0, 4000));
        return d;
    endfunction

    // Idles until every expected result has come and the unit has drained.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // The receiver stalls at random, with stall-free stretches.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        bit [15:0] settings [5];
        int        count;
        sb = new();
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: a tick from the reset state, extremes of every field and
        // the special velocity cases (none, no horizontal part, purely vertical).
        send_item(KIND_TICK, 184'hFFFF, 1'b0);
        send_item(KIND_LAUNCH, launch_word(0, 0, 0, 0, 0, 0), 1'b0);
        send_item(KIND_TICK, 184'hFFFF, 1'b0);
        send_item(KIND_LAUNCH, launch_word(0, 0, 0, 0, 0, 24'h7FFFFF), 1'b0);
        send_item(KIND_LAUNCH, launch_word(0, 0, 0, 0, 0, 24'h800000), 1'b0);
        send_item(KIND_LAUNCH, launch_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                           24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 1'b0);
        send_item(KIND_TICK, 184'hFFFF, 1'b0);
        send_item(KIND_LAUNCH, launch_word(32'h80000000, 32'h80000000, 32'h80000000,
                                           24'h800000, 24'h800000, 24'h800000), 1'b0);
        send_item(KIND_TICK, 184'hFFFF, 1'b0);
        send_item(KIND_LAUNCH, launch_word(5, 6, 7, 24'h000100, 0, 0), 1'b0);
        send_item(KIND_LAUNCH, launch_word(5, 6, 7, 24'hFFFF00, 0, 0), 1'b0);
        send_item(KIND_LAUNCH, launch_word(5, 6, 7, 0, 24'h000100, 24'h000100), 1'b0);
        send_item(KIND_LAUNCH, launch_word(5, 6, 7, 0, 24'hFFFF00, 24'hFFFF00), 1'b0);
        send_item(KIND_LAUNCH, launch_word(0, 0, 0, 24'hFFFF00, 24'hFFFF00, 24'h000100), 1'b0);
        send_item(KIND_TICK, {168'h0, 16'h0000}, 1'b0);
        send_item(KIND_TICK, {{168{1'b1}}, 16'h8000}, 1'b0);
        wait_drained();

        // Random flights under several gravity settings, extremes included.
        settings = '{16'd0, 16'hFFFF, 16'd2511, 16'd1, 16'($urandom)};
        foreach (settings[k])
        begin
            write_gravity(settings[k]);
            count = 0;
            while (count < 320)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(KIND_LAUNCH, random_launch(), $urandom_range(0, 2) == 0);
                else
                    send_item(KIND_TICK, random_tick(), $urandom_range(0, 2) == 0);
                count++;
            end
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== projectile_step_with_heading_unit.f =====
+incdir+hdl
hdl/pswh_pkg.sv
hdl/pswh_isqrt.sv
hdl/pswh_cordic.sv
hdl/projectile_step_with_heading_unit.sv
verif/tb_top.sv
